// ===== design/kfwe_pkg.sv =====
// Shared types and constants for the k-fingerprint window emitter.
// No dependencies; imported by the front, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package kfwe_pkg;

    localparam int LEN_W     = 16;  // factor length width
    localparam int OFF_W     = 24;  // window offset width
    localparam int WSIZE_W   = 5;   // window_size register width
    localparam int CMD_DEPTH = 2;   // front-to-back command queue
    localparam int OUT_DEPTH = 4;   // result queue

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;
    localparam logic [OFF_W-1:0]   OFF_MAX     = {OFF_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LENGTH = 2'd0,
        OP_OPEN   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // Work handed from the front to the back: a length or an end of read.
    typedef struct packed {
        logic             is_end;
        logic             sub;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // One window entry.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             sub;
        logic [OFF_W-1:0] offset;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ===== design/kfwe_fifo.sv =====
// Small synchronous first-in first-out queue, register based.
// Generic; used for the command queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module kfwe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/kfwe_front.sv =====
// Front end: accepts input words, tracks the sub-factor group, queues work.
// Depends on kfwe_pkg and kfwe_fifo.
`timescale 1ns / 1ps
`default_nettype none

module kfwe_front import kfwe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_operation,
    input  logic [LEN_W-1:0] i_factor_length,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop,
    output t_cmd             o_cmd
);

    t_op  op;
    logic accept;
    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    t_cmd cmd_in;
    logic r_in_sub, n_in_sub;

    assign op     = t_op'(i_operation);
    assign accept = i_push && !cmd_full;
    assign o_full = cmd_full;

    // group markers are absorbed here; lengths and end of read go on
    always_comb begin
        n_in_sub = r_in_sub;
        cmd_push = 1'b0;
        case (op)
            OP_LENGTH: begin
                cmd_push = accept;
            end
            OP_OPEN: begin
                if (accept) n_in_sub = 1'b1;
            end
            OP_CLOSE: begin
                if (accept) n_in_sub = 1'b0;
            end
            OP_END: begin
                if (accept) begin
                    cmd_push = 1'b1;
                    n_in_sub = 1'b0;
                end
            end
            default: begin
                cmd_push = 1'b0;
            end
        endcase
    end

    assign cmd_in.is_end = (op == OP_END);
    assign cmd_in.sub    = r_in_sub;
    assign cmd_in.len    = i_factor_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sub <= 1'b0;
        end else begin
            r_in_sub <= n_in_sub;
        end
    end

    kfwe_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty),
        .o_count ()
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== design/kfwe_back.sv =====
// Back end: ring store of the last k lengths, window readout, offset tracking.
// Depends on kfwe_pkg and kfwe_fifo (result queue).
`timescale 1ns / 1ps
`default_nettype none

module kfwe_back import kfwe_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] i_k,
    input  logic                            i_cmd_valid,
    input  t_cmd                            i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_res_empty,
    input  logic                            i_res_pop,
    output t_result                         o_res
);

    localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW  = $clog2(MAX_WINDOW+1);
    localparam int RCW = $clog2(OUT_DEPTH+1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state                r_state, n_state;
    logic [MAX_WINDOW-1:0] r_ring_vld, n_ring_vld;
    logic                  r_filling, n_filling;
    logic                  r_wpos_none, n_wpos_none;
    logic [PW-1:0]         r_wpos, n_wpos;
    logic [PW-1:0]         r_oldest, n_oldest;
    logic [OFF_W-1:0]      r_sum, n_sum;
    logic [PW-1:0]         r_pos, n_pos;
    logic [PW-1:0]         r_idx, n_idx;
    logic                  r_is_end, n_is_end;
    logic                  r_pending, n_pending;
    logic                  r_rd_first, n_rd_first;
    logic                  r_rd_last, n_rd_last;
    logic [LEN_W-1:0]      r_first_len, n_first_len;

    // ring memory: {sub bit, length}
    logic [LEN_W:0]        r_ring [MAX_WINDOW];
    logic [LEN_W:0]        r_rd_word;
    logic                  r_rd_vld;

    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [KW-1:0]         km1;
    logic [KW-1:0]         next_fill;
    logic                  need_red_o, need_red_w;
    logic                  can_issue;
    logic                  issue_last;
    logic [LEN_W-1:0]      rd_len;
    logic                  rd_sub;
    logic [LEN_W-1:0]      slide_len;
    logic [OFF_W:0]        sum_wide;
    logic [RCW-1:0]        res_count;
    t_result               res_in;

    assign km1        = i_k - KW'(1);
    assign next_fill  = r_wpos_none ? '0 : KW'(r_wpos) + KW'(1);
    assign need_red_o = (KW'(r_oldest) >= i_k);
    assign need_red_w = !r_filling && (KW'(r_wpos) >= i_k);
    assign can_issue  = ((RCW+1)'(res_count) + (RCW+1)'(r_pending)) < (RCW+1)'(OUT_DEPTH);
    assign issue_last = ((KW'(r_idx) + KW'(1)) == i_k);

    // never-written entries read as zero
    assign rd_len    = r_rd_vld ? r_rd_word[LEN_W-1:0] : '0;
    assign rd_sub    = r_rd_vld ? r_rd_word[LEN_W] : 1'b0;
    assign slide_len = r_rd_first ? rd_len : r_first_len;
    assign sum_wide  = {1'b0, r_sum} + (OFF_W+1)'(slide_len);

    always_comb begin
        n_state     = r_state;
        n_ring_vld  = r_ring_vld;
        n_filling   = r_filling;
        n_wpos_none = r_wpos_none;
        n_wpos      = r_wpos;
        n_oldest    = r_oldest;
        n_sum       = r_sum;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_is_end    = r_is_end;
        n_pending   = 1'b0;
        n_rd_first  = r_rd_first;
        n_rd_last   = r_rd_last;
        n_first_len = r_first_len;
        wr_en       = 1'b0;
        wr_addr     = r_wpos;
        o_cmd_pop   = 1'b0;

        if (r_pending && r_rd_first) begin
            n_first_len = rd_len;
        end

        case (r_state)
            S_IDLE: begin
                if (need_red_o || need_red_w) begin
                    // pointers left over from a larger k: one subtract per cycle
                    if (need_red_o) n_oldest = PW'(KW'(r_oldest) - i_k);
                    if (need_red_w) n_wpos = PW'(KW'(r_wpos) - i_k);
                end else if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_end) begin
                        if (r_filling) begin
                            n_state  = S_EMIT;
                            n_pos    = r_oldest;
                            n_idx    = '0;
                            n_is_end = 1'b1;
                        end else begin
                            n_ring_vld  = '0;
                            n_filling   = 1'b1;
                            n_wpos_none = 1'b1;
                            n_wpos      = '0;
                            n_oldest    = '0;
                            n_sum       = '0;
                        end
                    end else begin
                        wr_en    = 1'b1;
                        n_is_end = 1'b0;
                        if (r_filling) begin
                            n_wpos_none = 1'b0;
                            if (next_fill >= km1) begin
                                wr_addr   = PW'(km1);
                                n_filling = 1'b0;
                                n_wpos    = '0;
                                n_state   = S_EMIT;
                                n_pos     = r_oldest;
                                n_idx     = '0;
                            end else begin
                                wr_addr = PW'(next_fill);
                                n_wpos  = PW'(next_fill);
                            end
                        end else begin
                            wr_addr = r_wpos;
                            n_wpos  = ((KW'(r_wpos) + KW'(1)) == i_k) ? '0 : r_wpos + 1'b1;
                            n_state = S_EMIT;
                            n_pos   = r_oldest;
                            n_idx   = '0;
                        end
                        n_ring_vld[wr_addr] = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (can_issue) begin
                    n_pending  = 1'b1;
                    n_rd_first = (r_idx == '0);
                    n_rd_last  = issue_last;
                    n_idx      = r_idx + 1'b1;
                    n_pos      = ((KW'(r_pos) + KW'(1)) == i_k) ? '0 : r_pos + 1'b1;
                    if (issue_last) n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last entry is being queued this cycle
                n_state = S_IDLE;
                if (r_is_end) begin
                    n_ring_vld  = '0;
                    n_filling   = 1'b1;
                    n_wpos_none = 1'b1;
                    n_wpos      = '0;
                    n_oldest    = '0;
                    n_sum       = '0;
                end else begin
                    n_sum    = sum_wide[OFF_W] ? OFF_MAX : sum_wide[OFF_W-1:0];
                    n_oldest = ((KW'(r_oldest) + KW'(1)) == i_k) ? '0 : r_oldest + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring_vld  <= '0;
            r_filling   <= 1'b1;
            r_wpos_none <= 1'b1;
            r_wpos      <= '0;
            r_oldest    <= '0;
            r_sum       <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_is_end    <= 1'b0;
            r_pending   <= 1'b0;
            r_rd_first  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_first_len <= '0;
        end else begin
            r_state     <= n_state;
            r_ring_vld  <= n_ring_vld;
            r_filling   <= n_filling;
            r_wpos_none <= n_wpos_none;
            r_wpos      <= n_wpos;
            r_oldest    <= n_oldest;
            r_sum       <= n_sum;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_is_end    <= n_is_end;
            r_pending   <= n_pending;
            r_rd_first  <= n_rd_first;
            r_rd_last   <= n_rd_last;
            r_first_len <= n_first_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= {i_cmd.sub, i_cmd.len};
        end
        r_rd_word <= r_ring[r_pos];
        r_rd_vld  <= r_ring_vld[r_pos];
    end

    assign res_in.len    = rd_len;
    assign res_in.sub    = rd_sub;
    assign res_in.offset = r_sum;
    assign res_in.last   = r_rd_last;

    kfwe_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pending),
        .i_data  (res_in),
        .o_full  (),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty),
        .o_count (res_count)
    );

endmodule

`default_nettype wire

// ===== design/k_fingerprint_window_emitter_core.sv =====
// k-fingerprint window emitter: top level, window_size register, assertions.
// A window-completing length passes the command queue, ring write, ring read and result queue.
// A window of k entries holds the back end for one ring read per entry; it pops no new command
// until the window is out. Markers stay in the front; lengths that emit nothing only fill the ring.
// After k shrinks, each ring pointer at or above k is reduced by k, one subtract at a time, before new work is taken.
// Reset: i_rst_n synchronous, active low; clears queues, ring valid bits, counters; k returns to 4.
`timescale 1ns / 1ps
`default_nettype none

module k_fingerprint_window_emitter_core import kfwe_pkg::*; #(
    parameter int MAX_WINDOW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word queue
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_operation,
    input  logic [LEN_W-1:0]   i_factor_length,
    // result word queue
    output logic               empty,
    input  logic               pop,
    output logic [LEN_W-1:0]   o_window_length,
    output logic               o_sub_factor_bit,
    output logic [OFF_W-1:0]   o_window_offset,
    output logic               o_last_of_window,
    // window_size write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WSIZE_W-1:0] i_cfg_window_size
);

    localparam int KW   = $clog2(MAX_WINDOW+1);
    localparam int CMPW = (KW > WSIZE_W) ? KW : WSIZE_W;

    logic [WSIZE_W-1:0] r_window_size;
    logic [KW-1:0]      eff_k;
    logic               cmd_valid;
    logic               cmd_pop;
    t_cmd               cmd;
    t_result            res;

    // ------------------------------------------------------------------
    // Configuration. The user must write the register only while the block
    // is idle, so the back end may read k live; the block itself does not
    // enforce it. A size of zero acts as one, above MAX_WINDOW as MAX_WINDOW.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WSIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    always_comb begin
        if (r_window_size == '0) begin
            eff_k = KW'(1);
        end else if (CMPW'(r_window_size) > CMPW'(MAX_WINDOW)) begin
            eff_k = KW'(MAX_WINDOW);
        end else begin
            eff_k = KW'(r_window_size);
        end
    end

    // ------------------------------------------------------------------
    // Front: takes input words unless full, folds group open/close into the
    // sub-factor flag and queues lengths and end-of-read for the back.
    // ------------------------------------------------------------------
    kfwe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_operation     (i_operation),
        .i_factor_length (i_factor_length),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_pop       (cmd_pop),
        .o_cmd           (cmd)
    );

    // ------------------------------------------------------------------
    // Back: ring store, fill tracking, window readout one entry per cycle
    // while the result queue has room, then slides the oldest length into
    // the running offset (saturating at 24 bits), or clears at end of read.
    // ------------------------------------------------------------------
    kfwe_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k         (eff_k),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_empty (empty),
        .i_res_pop   (pop),
        .o_res       (res)
    );

    assign o_window_length  = res.len;
    assign o_sub_factor_bit = res.sub;
    assign o_window_offset  = res.offset;
    assign o_last_of_window = res.last;

`ifndef NO_ASSERTIONS
    // back end only takes work that the front has queued
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // a full input side means queued work is waiting for the back end
    a_full_has_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> cmd_valid)
        else $error("input full with no queued command");

    // reset leaves the result queue empty and the command queue not full
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire
